FILE: rtl/core/fsg_pkg.sv
// ----------------------------------------------------------------------------
// fsg_pkg
// Shared constants for the footswitch gesture detector: default widths,
// register indexes, reset values and result bit positions.
// ----------------------------------------------------------------------------
package fsg_pkg;

  localparam int TIMER_WIDTH_DEF  = 32;
  localparam int FILTER_WIDTH_DEF = 16;

  localparam int COEFF_W = 16;
  localparam int MS_W    = 16;
  localparam int DT_W    = 16;
  // ms * 1000 fits in 26 bits for a 16-bit ms value
  localparam int US_W    = 26;
  localparam int US_PER_MS = 1000;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_COEFF = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_MS        = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BOTH_MS        = 2'd2;

  localparam logic [COEFF_W-1:0] COEFF_RST   = 16'd6237;
  localparam logic [US_W-1:0]    HOLD_US_RST = 26'd500000;
  localparam logic [US_W-1:0]    BOTH_US_RST = 26'd300000;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // result bit positions in out_tdata
  localparam int OB_FIRST_TAP      = 0;
  localparam int OB_FIRST_HOLD     = 1;
  localparam int OB_SECOND_TAP     = 2;
  localparam int OB_SECOND_HOLD    = 3;
  localparam int OB_GESTURE_START  = 4;
  localparam int OB_GESTURE_END    = 5;
  localparam int OB_GESTURE_ACTIVE = 6;
  localparam int OB_FIRST_PRESSED  = 7;
  localparam int OB_SECOND_PRESSED = 8;
  localparam int OUT_FIELDS        = 9;

endpackage

FILE: rtl/core/footswitch_gesture_detector.sv
// ----------------------------------------------------------------------------
// footswitch_gesture_detector
// Two-switch debounce with tap, hold and both-held gesture reporting.
// ----------------------------------------------------------------------------
// One item per tick, one result item per tick. An item is registered on
// entry in the input register, processed by the integrator multiply,
// thresholds, timers and gesture logic as it leaves that register, and lands
// in the result register, which drives out_tvalid; one item per clock
// sustained while out_tready stays high. The integrator multiply (coefficient
// by level error, one per switch) sets the critical path. hold_ms and both_ms
// are converted to microseconds as they are written.
module footswitch_gesture_detector #(
  parameter int TIMER_WIDTH  = fsg_pkg::TIMER_WIDTH_DEF,
  parameter int FILTER_WIDTH = fsg_pkg::FILTER_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] raw_first, [1] raw_second, [17:2] dt_us, rest zero
  input  logic [fsg_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] first_tap, [1] first_hold, [2] second_tap, [3] second_hold,
  // [4] gesture_start, [5] gesture_end, [6] gesture_active,
  // [7] first_pressed, [8] second_pressed, rest zero
  output logic [fsg_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [fsg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [fsg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int FW     = FILTER_WIDTH;
  localparam int TW     = TIMER_WIDTH;
  localparam int PW     = FW + fsg_pkg::COEFF_W;
  localparam int CW     = (TW > fsg_pkg::US_W) ? TW : fsg_pkg::US_W;
  localparam logic [FW-1:0] FULL_SCALE  = {FW{1'b1}};
  localparam logic [FW-1:0] PRESS_LEVEL = FW'(3) << (FW - 2);
  localparam logic [FW-1:0] REL_LEVEL   = FW'(1) << (FW - 2);
  localparam logic [TW-1:0] TIMER_MAX   = {TW{1'b1}};
  localparam logic [PW-1:0] ROUND_HALF  = PW'(32768);

  // configuration
  logic [fsg_pkg::COEFF_W-1:0] coeff_r;
  logic [fsg_pkg::US_W-1:0]    hold_us_r;
  logic [fsg_pkg::US_W-1:0]    both_us_r;
  logic [fsg_pkg::US_W-1:0]    cfg_us;

  assign cfg_us = fsg_pkg::US_W'(cfg_wdata) * fsg_pkg::US_W'(fsg_pkg::US_PER_MS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r   <= fsg_pkg::COEFF_RST;
      hold_us_r <= fsg_pkg::HOLD_US_RST;
      both_us_r <= fsg_pkg::BOTH_US_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fsg_pkg::REG_DEBOUNCE_COEFF: coeff_r   <= cfg_wdata;
        fsg_pkg::REG_HOLD_MS:        hold_us_r <= cfg_us;
        fsg_pkg::REG_BOTH_MS:        both_us_r <= cfg_us;
        default: ;
      endcase
    end
  end

  // handshake: input register then result register
  logic                            s1_valid_r;
  logic [1:0]                      s1_raw_r;
  logic [fsg_pkg::DT_W-1:0]        s1_dt_r;
  logic                            out_valid_r;
  logic [fsg_pkg::OUT_FIELDS-1:0]  out_bits_r;
  logic                            adv;
  logic                            in_acc;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_raw_r <= in_tdata[1:0];
      s1_dt_r  <= in_tdata[2 +: fsg_pkg::DT_W];
    end
  end

  // state
  logic [FW-1:0] level_r [2];
  logic [1:0]    pressed_r;
  logic [TW-1:0] held_r [2];
  logic [1:0]    hold_done_r;
  logic [1:0]    used_r;
  logic          gest_run_r;
  logic [TW-1:0] gest_time_r;

  logic [FW-1:0] level_nxt [2];
  logic [1:0]    pressed_nxt;
  logic [TW-1:0] held_nxt [2];
  logic [1:0]    hold_done_nxt;
  logic [1:0]    used_nxt;
  logic          gest_run_nxt;
  logic [TW-1:0] gest_time_nxt;
  logic [fsg_pkg::OUT_FIELDS-1:0] out_bits_nxt;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] t,
                                            input logic [fsg_pkg::DT_W-1:0] dt);
    logic [TW:0] s;
    s = {1'b0, t} + (TW+1)'(dt);
    return s[TW] ? TIMER_MAX : s[TW-1:0];
  endfunction

  always_comb begin
    logic [FW-1:0] lvl;
    logic [FW-1:0] tgt;
    logic [FW-1:0] diff;
    logic [PW-1:0] prod;
    logic [FW-1:0] mag;
    logic          up;
    logic          p;
    logic [1:0]    tap;
    logic [1:0]    hold;
    logic          g_start;
    logic          g_end;

    tap     = 2'b00;
    hold    = 2'b00;
    g_start = 1'b0;
    g_end   = 1'b0;
    hold_done_nxt = hold_done_r;
    used_nxt      = used_r;
    gest_run_nxt  = gest_run_r;

    for (int k = 0; k < 2; k++) begin
      lvl  = level_r[k];
      tgt  = s1_raw_r[k] ? FULL_SCALE : '0;
      up   = tgt >= lvl;
      diff = up ? (tgt - lvl) : (lvl - tgt);
      prod = PW'(coeff_r) * PW'(diff) + ROUND_HALF;
      mag  = prod[PW-1:fsg_pkg::COEFF_W];
      level_nxt[k] = up ? (lvl + mag) : (lvl - mag);
      p = pressed_r[k];
      if (!p && level_nxt[k] > PRESS_LEVEL) p = 1'b1;
      if (p && level_nxt[k] < REL_LEVEL) p = 1'b0;
      pressed_nxt[k] = p;
      held_nxt[k]    = p ? sat_add(held_r[k], s1_dt_r) : '0;
    end

    if (pressed_nxt[0] && pressed_nxt[1]) begin
      gest_time_nxt = sat_add(gest_time_r, s1_dt_r);
      if (!gest_run_r && CW'(gest_time_nxt) >= CW'(both_us_r)) begin
        gest_run_nxt  = 1'b1;
        g_start       = 1'b1;
        used_nxt      = 2'b11;
        hold_done_nxt = 2'b11;
      end
    end else begin
      gest_time_nxt = '0;
      if (gest_run_r && !pressed_nxt[0] && !pressed_nxt[1]) begin
        gest_run_nxt = 1'b0;
        g_end        = 1'b1;
      end
    end

    for (int k = 0; k < 2; k++) begin
      if (pressed_nxt[k] && !hold_done_nxt[k] && CW'(held_nxt[k]) >= CW'(hold_us_r)) begin
        hold_done_nxt[k] = 1'b1;
        if (!gest_run_nxt && !used_nxt[k]) hold[k] = 1'b1;
      end
      if (pressed_r[k] && !pressed_nxt[k]) begin
        if (!hold_done_nxt[k] && !gest_run_nxt && !used_nxt[k]) tap[k] = 1'b1;
        used_nxt[k]      = 1'b0;
        hold_done_nxt[k] = 1'b0;
      end
    end

    out_bits_nxt = '0;
    out_bits_nxt[fsg_pkg::OB_FIRST_TAP]      = tap[0];
    out_bits_nxt[fsg_pkg::OB_FIRST_HOLD]     = hold[0];
    out_bits_nxt[fsg_pkg::OB_SECOND_TAP]     = tap[1];
    out_bits_nxt[fsg_pkg::OB_SECOND_HOLD]    = hold[1];
    out_bits_nxt[fsg_pkg::OB_GESTURE_START]  = g_start;
    out_bits_nxt[fsg_pkg::OB_GESTURE_END]    = g_end;
    out_bits_nxt[fsg_pkg::OB_GESTURE_ACTIVE] = gest_run_nxt;
    out_bits_nxt[fsg_pkg::OB_FIRST_PRESSED]  = pressed_nxt[0];
    out_bits_nxt[fsg_pkg::OB_SECOND_PRESSED] = pressed_nxt[1];
  end

  logic step;
  assign step = s1_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r[0]  <= '0;
      level_r[1]  <= '0;
      held_r[0]   <= '0;
      held_r[1]   <= '0;
      pressed_r   <= '0;
      hold_done_r <= '0;
      used_r      <= '0;
      gest_run_r  <= 1'b0;
      gest_time_r <= '0;
    end else if (step) begin
      level_r[0]  <= level_nxt[0];
      level_r[1]  <= level_nxt[1];
      held_r[0]   <= held_nxt[0];
      held_r[1]   <= held_nxt[1];
      pressed_r   <= pressed_nxt;
      hold_done_r <= hold_done_nxt;
      used_r      <= used_nxt;
      gest_run_r  <= gest_run_nxt;
      gest_time_r <= gest_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_bits_r <= out_bits_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = fsg_pkg::OUT_TDATA_W'(out_bits_r);

endmodule

FILE: rtl/core/fsg_checker.sv
// ----------------------------------------------------------------------------
// fsg_checker
// Port-level checks for the footswitch gesture detector, bound to the top.
// ----------------------------------------------------------------------------
module fsg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fsg_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic g_start, g_end, g_act, tap0, tap1, p0, p1;
  assign g_start = out_tdata[fsg_pkg::OB_GESTURE_START];
  assign g_end   = out_tdata[fsg_pkg::OB_GESTURE_END];
  assign g_act   = out_tdata[fsg_pkg::OB_GESTURE_ACTIVE];
  assign tap0    = out_tdata[fsg_pkg::OB_FIRST_TAP];
  assign tap1    = out_tdata[fsg_pkg::OB_SECOND_TAP];
  assign p0      = out_tdata[fsg_pkg::OB_FIRST_PRESSED];
  assign p1      = out_tdata[fsg_pkg::OB_SECOND_PRESSED];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && g_start |-> g_act && p0 && p1 && !g_end)
    else $error("gesture start without both switches held");

  a_end_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && g_end |-> !g_act && !p0 && !p1)
    else $error("gesture end with a switch still pressed");

  a_tap_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (tap0 || tap1) |-> !g_act && !(tap0 && p0) && !(tap1 && p1))
    else $error("tap reported while pressed or during gesture");

endmodule

bind footswitch_gesture_detector fsg_checker u_fsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
